### hdl/vpa_pkg.sv
`timescale 1ns / 1ps
package vpa_pkg;

   localparam int MAX_GRANTS_DEF = 16;
   localparam int FREE_SLOTS_DEF = 17;
   localparam int ADDR_BITS_DEF  = 16;

   localparam logic [1:0] REG_FIT_POLICY = 2'd0;
   localparam logic [1:0] REG_POOL_SIZE  = 2'd1;
   localparam logic [1:0] REG_POOL_BASE  = 2'd2;
   localparam logic [1:0] REG_MIN_SLICE  = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_FIT   = 3'd1;
   localparam logic [2:0] ST_NOT_FND  = 3'd2;
   localparam logic [2:0] ST_ZERO     = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GSCAN,
      S_FSCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   // candidate compare done by the shared unit
   typedef struct packed {
      logic start;   // start scan
      logic step;    // advance one slot
   } scan_ctl_type;

endpackage

### hdl/vpa_cmp.sv
`timescale 1ns / 1ps
// shared compare unit: judges one free slot against the current pick
module vpa_cmp #(
   parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF
) (
   input  logic [1:0]           policy,
   input  logic                 cand_ok,
   input  logic                 have_best,
   input  logic [15:0]          cand_len,
   input  logic [ADDR_BITS-1:0] cand_start,
   input  logic [15:0]          best_len,
   input  logic [ADDR_BITS-1:0] best_start,
   output logic                 take
);
   import vpa_pkg::*;

   logic better;

   // policy order, lowest start breaks ties
   always_comb begin
      better = cand_start < best_start;
      case (policy)
         POL_BEST: begin
            if (cand_len != best_len) better = cand_len < best_len;
         end
         POL_WORST: begin
            if (cand_len != best_len) better = cand_len > best_len;
         end
         default: better = cand_start < best_start;
      endcase
      take = cand_ok && (!have_best || better);
   end

endmodule

### hdl/variable_partition_allocator.sv
`timescale 1ns / 1ps
// an accepted request runs one grant-table scan and one free-table scan (on allocate through the
// single compare unit), then a commit, before the result is valid
// zero-size allocate leaves the grant scan at its first slot and goes straight to the result
// throughput: one item at a time; a new request is taken only once the result has been taken,
// so result stalls hold off the next request
// reset: synchronous, registers to defaults, one free region of the pool
module variable_partition_allocator #(
   parameter int MAX_GRANTS = vpa_pkg::MAX_GRANTS_DEF,
   parameter int FREE_SLOTS = vpa_pkg::FREE_SLOTS_DEF,
   parameter int ADDR_BITS  = vpa_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_req_size,
   input  logic [7:0]  req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_granted_id,
   output logic [15:0] rsp_grant_addr,
   output logic [15:0] rsp_grant_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import vpa_pkg::*;

   localparam int GB = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
   localparam int FB = $clog2(FREE_SLOTS);
   localparam int IB = ((GB > FB) ? GB : FB) + 1;

   // configuration
   logic [1:0]  policy_ff;
   logic [15:0] psize_ff, pbase_ff, mslice_ff;
   logic        reload;

   // tables
   logic [ADDR_BITS-1:0] fstart_ff [FREE_SLOTS];
   logic [15:0]          flen_ff   [FREE_SLOTS];
   logic [FREE_SLOTS-1:0] fvalid_ff;
   logic [7:0]           uid_ff    [MAX_GRANTS];
   logic [ADDR_BITS-1:0] ustart_ff [MAX_GRANTS];
   logic [15:0]          ulen_ff   [MAX_GRANTS];
   logic [MAX_GRANTS-1:0] uvalid_ff;
   logic [7:0]           idc_ff;

   state_type state_ff, state_in;
   logic [IB-1:0] idx_ff;
   logic        cmd_ff;
   logic [15:0] size_ff;
   logic [7:0]  id_ff;

   // scan results
   logic        gfound_ff, bfound_ff, lfound_ff, rfound_ff, efound_ff;
   logic [GB-1:0] gidx_ff;
   logic [FB-1:0] bidx_ff, lidx_ff, ridx_ff, eidx_ff;
   logic [ADDR_BITS-1:0] s_ff, e_ff;
   logic [15:0] l_ff;

   logic [2:0]  st_ff;
   logic [15:0] oaddr_ff, osize_ff;
   logic [7:0]  oid_ff;

   logic [FB-1:0] fi;
   logic [GB-1:0] gi;
   logic take, cand_ok, gdone, fdone;
   logic [ADDR_BITS-1:0] fend;

   assign fi = idx_ff[FB-1:0];
   assign gi = idx_ff[GB-1:0];
   assign gdone = (idx_ff == IB'(MAX_GRANTS - 1));
   assign fdone = (idx_ff == IB'(FREE_SLOTS - 1));
   assign cand_ok = fvalid_ff[fi] && (flen_ff[fi] >= size_ff);
   assign fend = fstart_ff[fi] + ADDR_BITS'(flen_ff[fi]);

   vpa_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmp (
      .policy(policy_ff), .cand_ok(cand_ok), .have_best(bfound_ff),
      .cand_len(flen_ff[fi]), .cand_start(fstart_ff[fi]),
      .best_len(flen_ff[bidx_ff]), .best_start(fstart_ff[bidx_ff]),
      .take(take));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_status = st_ff;
   assign rsp_granted_id = oid_ff;
   assign rsp_grant_addr = oaddr_ff;
   assign rsp_grant_size = osize_ff;
   assign reload = csr_valid && csr_ready &&
                   (csr_index == REG_POOL_SIZE || csr_index == REG_POOL_BASE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_GSCAN;
         S_GSCAN: begin
            if (cmd_ff == CMD_ALLOC && (size_ff == '0)) state_in = S_DONE;
            else if (gdone) state_in = S_FSCAN;
         end
         S_FSCAN: begin
            if (fdone) state_in = S_COMMIT;
         end
         S_COMMIT: state_in = S_DONE;
         S_DONE:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         policy_ff <= POL_FIRST;
         psize_ff  <= 16'd1024;
         pbase_ff  <= '0;
         mslice_ff <= 16'd10;
         idc_ff    <= '0;
         uvalid_ff <= '0;
         fvalid_ff <= FREE_SLOTS'(1);
         fstart_ff[0] <= '0;
         flen_ff[0] <= 16'd1024;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FIT_POLICY: policy_ff <= csr_data[1:0];
               REG_POOL_SIZE:  psize_ff  <= csr_data;
               REG_POOL_BASE:  pbase_ff  <= csr_data;
               default:        mslice_ff <= csr_data;
            endcase
         end
         if (reload) begin
            uvalid_ff <= '0;
            fvalid_ff <= FREE_SLOTS'(1);
            fstart_ff[0] <= (csr_index == REG_POOL_BASE) ?
                            ADDR_BITS'(csr_data) : ADDR_BITS'(pbase_ff);
            flen_ff[0] <= (csr_index == REG_POOL_SIZE) ? csr_data : psize_ff;
         end
         case (state_ff)
            S_IDLE: begin
               cmd_ff <= req_cmd;
               size_ff <= req_req_size;
               id_ff <= req_owner_id;
               idx_ff <= '0;
               gfound_ff <= 1'b0; bfound_ff <= 1'b0; lfound_ff <= 1'b0;
               rfound_ff <= 1'b0; efound_ff <= 1'b0;
               gidx_ff <= '0; bidx_ff <= '0;
               if (req_valid) begin
                  if (req_cmd == CMD_ALLOC) begin
                     idc_ff <= idc_ff + 8'd1;
                     oid_ff <= idc_ff + 8'd1;
                  end else oid_ff <= req_owner_id;
               end
            end
            // grant table scan: empty slot or matching id
            S_GSCAN: begin
               if (!gfound_ff) begin
                  if (cmd_ff == CMD_ALLOC && !uvalid_ff[gi]) begin
                     gfound_ff <= 1'b1; gidx_ff <= gi;
                  end
                  if (cmd_ff == CMD_FREE && uvalid_ff[gi] && uid_ff[gi] == id_ff) begin
                     gfound_ff <= 1'b1; gidx_ff <= gi;
                     s_ff <= ustart_ff[gi];
                     l_ff <= ulen_ff[gi];
                     e_ff <= ustart_ff[gi] + ADDR_BITS'(ulen_ff[gi]);
                  end
               end
               idx_ff <= gdone ? '0 : idx_ff + 1'b1;
               if (cmd_ff == CMD_ALLOC && size_ff == '0) begin
                  st_ff <= ST_ZERO; oaddr_ff <= '0; osize_ff <= '0;
               end
            end
            // free table scan: pick through the shared compare on allocate, neighbours and an empty slot on free
            S_FSCAN: begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (take) begin bfound_ff <= 1'b1; bidx_ff <= fi; end
               end else begin
                  if (!fvalid_ff[fi]) begin
                     if (!efound_ff) begin efound_ff <= 1'b1; eidx_ff <= fi; end
                  end else if (!lfound_ff && fend == s_ff) begin
                     lfound_ff <= 1'b1; lidx_ff <= fi;
                  end else if (!rfound_ff && fstart_ff[fi] == e_ff) begin
                     rfound_ff <= 1'b1; ridx_ff <= fi;
                  end
               end
               if (!fdone) idx_ff <= idx_ff + 1'b1;
            end
            // apply the table update
            S_COMMIT: begin
               oaddr_ff <= '0; osize_ff <= '0;
               if (cmd_ff == CMD_ALLOC) begin
                  if (!gfound_ff) st_ff <= ST_FULL;
                  else if (!bfound_ff) st_ff <= ST_NO_FIT;
                  else begin
                     st_ff <= ST_OK;
                     uvalid_ff[gidx_ff] <= 1'b1;
                     uid_ff[gidx_ff] <= oid_ff;
                     ustart_ff[gidx_ff] <= fstart_ff[bidx_ff];
                     oaddr_ff <= 16'(fstart_ff[bidx_ff]);
                     if ((flen_ff[bidx_ff] - size_ff) > mslice_ff) begin
                        fstart_ff[bidx_ff] <= fstart_ff[bidx_ff] + ADDR_BITS'(size_ff);
                        flen_ff[bidx_ff] <= flen_ff[bidx_ff] - size_ff;
                        ulen_ff[gidx_ff] <= size_ff;
                        osize_ff <= size_ff;
                     end else begin
                        fvalid_ff[bidx_ff] <= 1'b0;
                        ulen_ff[gidx_ff] <= flen_ff[bidx_ff];
                        osize_ff <= flen_ff[bidx_ff];
                     end
                  end
               end else if (!gfound_ff) st_ff <= ST_NOT_FND;
               else if (!lfound_ff && !rfound_ff && !efound_ff) st_ff <= ST_FULL;
               else begin
                  st_ff <= ST_OK;
                  uvalid_ff[gidx_ff] <= 1'b0;
                  oaddr_ff <= 16'(s_ff);
                  osize_ff <= l_ff;
                  if (lfound_ff && rfound_ff) begin
                     flen_ff[lidx_ff] <= flen_ff[lidx_ff] + l_ff + flen_ff[ridx_ff];
                     fvalid_ff[ridx_ff] <= 1'b0;
                  end else if (lfound_ff) begin
                     flen_ff[lidx_ff] <= flen_ff[lidx_ff] + l_ff;
                  end else if (rfound_ff) begin
                     fstart_ff[ridx_ff] <= s_ff;
                     flen_ff[ridx_ff] <= flen_ff[ridx_ff] + l_ff;
                  end else begin
                     fvalid_ff[eidx_ff] <= 1'b1;
                     fstart_ff[eidx_ff] <= s_ff;
                     flen_ff[eidx_ff] <= l_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready && !csr_ready)
      else $error("ready while busy");
   a_alloc_id: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_ALLOC) |=> idc_ff == $past(idc_ff) + 8'd1)
      else $error("id not taken");
   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_grant_size == '0)
      else $error("size on failure");
`endif

endmodule
